### hw/rtl/mexp_pkg.sv
// Package for the modular exponentiation unit.
// Holds the sequencer state type, the fixed base width and the reset modulus. No dependencies.
package mexp_pkg;

  localparam int BASE_W = 63;
  localparam logic [63:0] MOD_RESET_VAL = 64'd1000000007;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_SQUARE,
    ST_MULT,
    ST_DONE
  } mexp_state_t;

endpackage

### hw/rtl/mexp_cell.sv
// One double-and-add cell of the modular multiplier chain.
// Stand-alone; instantiated by mexp_chain.
module mexp_cell #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         vld_i,
  input  logic [W-1:0] acc_i,
  input  logic [W-1:0] x_i,
  input  logic [W:0]   m_i,
  input  logic         bit_i,
  output logic         vld_o,
  output logic [W-1:0] acc_o
);

  logic         vld_r;
  logic [W-1:0] acc_r;
  logic [W-1:0] dbl;
  logic [W-1:0] acc_nxt;

  // (a + b) mod m for a, b < m; m of 2^W folds to plain truncation
  function automatic logic [W-1:0] add_mod(input logic [W-1:0] a, input logic [W-1:0] b,
                                           input logic [W:0] m);
    logic [W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= m) s = s - m;
    return s[W-1:0];
  endfunction

  always_comb begin
    dbl     = add_mod(acc_i, acc_i, m_i);
    acc_nxt = bit_i ? add_mod(dbl, x_i, m_i) : dbl;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
    acc_r <= acc_nxt;
  end

  assign vld_o = vld_r;
  assign acc_o = acc_r;

endmodule

### hw/rtl/mexp_chain.sv
// Modular multiplier: a row of W double-and-add cells, MSB of y first.
// Depends on mexp_cell. x, y and m must hold while a product is in flight.
module mexp_chain #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] x,
  input  logic [W-1:0] y,
  input  logic [W:0]   m,
  output logic         done,
  output logic [W-1:0] prod
);

  logic         vld [0:W];
  logic [W-1:0] acc [0:W];

  assign vld[0] = start;
  assign acc[0] = '0;

  for (genvar k = 0; k < W; k++) begin : g_cell
    mexp_cell #(.W(W)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .vld_i (vld[k]),
      .acc_i (acc[k]),
      .x_i   (x),
      .m_i   (m),
      .bit_i (y[W-1-k]),
      .vld_o (vld[k+1]),
      .acc_o (acc[k+1])
    );
  end

  assign done = vld[W];
  assign prod = acc[W];

endmodule

### hw/rtl/modular_exponentiation_unit.sv
// Modular exponentiation unit, square-and-multiply over the exponent MSB first.
// Depends on mexp_pkg and mexp_chain.
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall   | in_base, in_exponent
//  out     | output    | out_valid/out_stall | out_power
//  cfg     | input     | cfg_valid/cfg_ready | cfg_modulus
//
// One item at a time. The base is first reduced bit by bit, MSB first, then each
// exponent bit costs a squaring plus a multiply when set, each a pass through the
// cell chain; an exponent of zero goes straight to DONE with a result of 1.
// Synchronous active-low reset restores modulus 1000000007.
// A finished result waits in DONE while the output register is held by out_stall.
module modular_exponentiation_unit #(
  parameter int MOD_WIDTH = 32,
  parameter int EXP_WIDTH = 63
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [mexp_pkg::BASE_W-1:0]  in_base,
  input  logic [EXP_WIDTH-1:0]         in_exponent,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [MOD_WIDTH-1:0]         out_power,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [MOD_WIDTH-1:0]         cfg_modulus
);

  import mexp_pkg::*;

  localparam int RCW = $clog2(BASE_W);
  localparam int ECW = (EXP_WIDTH > 1) ? $clog2(EXP_WIDTH) : 1;

  mexp_state_t          state_r, state_nxt;
  logic [MOD_WIDTH-1:0] mod_r;
  logic [BASE_W-1:0]    base_r, base_nxt;
  logic [EXP_WIDTH-1:0] exp_r, exp_nxt;
  logic [MOD_WIDTH-1:0] b_r, b_nxt;
  logic [MOD_WIDTH-1:0] acc_r, acc_nxt;
  logic [RCW-1:0]       rcnt_r, rcnt_nxt;
  logic [ECW-1:0]       ecnt_r, ecnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 ov_r, ov_nxt;
  logic [MOD_WIDTH-1:0] pw_r, pw_nxt;

  logic [MOD_WIDTH:0]   m_ext;
  logic [MOD_WIDTH:0]   red_s;
  logic [MOD_WIDTH-1:0] red_v;
  logic                 mul_start, mul_done;
  logic [MOD_WIDTH-1:0] mul_y, mul_p;
  logic [MOD_WIDTH-1:0] one_mod;

  // modulus zero stands for 2^MOD_WIDTH
  assign m_ext = {(mod_r == '0), mod_r};

  always_comb begin
    red_s = {acc_r, base_r[BASE_W-1]};
    if (red_s >= m_ext) red_s = red_s - m_ext;
    red_v = red_s[MOD_WIDTH-1:0];
  end

  assign one_mod   = (m_ext == {{MOD_WIDTH{1'b0}}, 1'b1}) ? '0 : {{(MOD_WIDTH-1){1'b0}}, 1'b1};
  assign mul_start = ((state_r == ST_SQUARE) || (state_r == ST_MULT)) && !busy_r;
  assign mul_y     = (state_r == ST_SQUARE) ? acc_r : b_r;

  mexp_chain #(.W(MOD_WIDTH)) u_chain (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .x     (acc_r),
    .y     (mul_y),
    .m     (m_ext),
    .done  (mul_done),
    .prod  (mul_p)
  );

  always_comb begin
    state_nxt = state_r;
    base_nxt  = base_r;
    exp_nxt   = exp_r;
    b_nxt     = b_r;
    acc_nxt   = acc_r;
    rcnt_nxt  = rcnt_r;
    ecnt_nxt  = ecnt_r;
    busy_nxt  = busy_r;
    ov_nxt    = ov_r && out_stall;
    pw_nxt    = pw_r;
    if (mul_start) busy_nxt = 1'b1;
    else if (mul_done) busy_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          base_nxt = in_base;
          exp_nxt  = in_exponent;
          rcnt_nxt = '0;
          if (in_exponent == '0) begin
            acc_nxt   = {{(MOD_WIDTH-1){1'b0}}, 1'b1};
            state_nxt = ST_DONE;
          end else begin
            acc_nxt   = '0;
            state_nxt = ST_REDUCE;
          end
        end
      end
      ST_REDUCE: begin
        acc_nxt  = red_v;
        base_nxt = {base_r[BASE_W-2:0], 1'b0};
        rcnt_nxt = rcnt_r + 1'b1;
        if (rcnt_r == RCW'(BASE_W - 1)) begin
          b_nxt     = red_v;
          acc_nxt   = one_mod;
          ecnt_nxt  = '0;
          state_nxt = ST_SQUARE;
        end
      end
      ST_SQUARE, ST_MULT: begin
        if (mul_done) begin
          acc_nxt = mul_p;
          if ((state_r == ST_SQUARE) && exp_r[EXP_WIDTH-1]) begin
            state_nxt = ST_MULT;
          end else begin
            exp_nxt  = exp_r << 1;
            ecnt_nxt = ecnt_r + 1'b1;
            state_nxt = (ecnt_r == ECW'(EXP_WIDTH - 1)) ? ST_DONE : ST_SQUARE;
          end
        end
      end
      ST_DONE: begin
        if (!ov_r || !out_stall) begin
          ov_nxt    = 1'b1;
          pw_nxt    = acc_r;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      mod_r   <= MOD_RESET_VAL[MOD_WIDTH-1:0];
      busy_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= busy_nxt;
      ov_r    <= ov_nxt;
      if (cfg_valid) mod_r <= cfg_modulus;
    end
    base_r <= base_nxt;
    exp_r  <= exp_nxt;
    b_r    <= b_nxt;
    acc_r  <= acc_nxt;
    rcnt_r <= rcnt_nxt;
    ecnt_r <= ecnt_nxt;
    pw_r   <= pw_nxt;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = ov_r;
  assign out_power = pw_r;

endmodule

### verif/mexp_checker.sv
// Checker for the modular exponentiation unit: watches the in, out and cfg channels,
// predicts each power with a square-and-multiply model and compares. Depends on mexp_pkg.
`timescale 1ns / 100ps
module mexp_checker #(
  parameter int MOD_WIDTH = 32,
  parameter int EXP_WIDTH = 63
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [mexp_pkg::BASE_W-1:0] in_base,
  input  logic [EXP_WIDTH-1:0]        in_exponent,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [MOD_WIDTH-1:0]        out_power,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [MOD_WIDTH-1:0]        cfg_modulus,
  output int                          fail_count,
  output int                          pending_powers,
  output int                          powers_seen
);

  localparam int REG_MODULUS = 0;

  logic [MOD_WIDTH-1:0] modulus_q;
  logic [MOD_WIDTH-1:0] power_queue[$];
  int mismatches;

  // exact product reduction; modulus zero acts as 2^MOD_WIDTH
  function automatic logic [MOD_WIDTH-1:0] mul_reduce(logic [MOD_WIDTH-1:0] x,
                                                      logic [MOD_WIDTH-1:0] y,
                                                      logic [MOD_WIDTH-1:0] m);
    logic [2*MOD_WIDTH-1:0] prod;
    prod = {{MOD_WIDTH{1'b0}}, x} * {{MOD_WIDTH{1'b0}}, y};
    if (m == 0) return prod[MOD_WIDTH-1:0];
    return MOD_WIDTH'(prod % {{MOD_WIDTH{1'b0}}, m});
  endfunction

  function automatic logic [MOD_WIDTH-1:0] predict_power(logic [mexp_pkg::BASE_W-1:0] b,
                                                         logic [EXP_WIDTH-1:0] e,
                                                         logic [MOD_WIDTH-1:0] m);
    logic [MOD_WIDTH-1:0] bred;
    logic [MOD_WIDTH-1:0] acc;
    if (e == 0) return MOD_WIDTH'(1);
    if (m == 0) begin
      bred = b[MOD_WIDTH-1:0];
      acc  = MOD_WIDTH'(1);
    end else begin
      bred = MOD_WIDTH'(64'(b) % 64'(m));
      acc  = (m == 1) ? '0 : MOD_WIDTH'(1);
    end
    for (int i = EXP_WIDTH - 1; i >= 0; i--) begin
      acc = mul_reduce(acc, acc, m);
      if (e[i]) acc = mul_reduce(acc, bred, m);
    end
    return acc;
  endfunction

  assign fail_count     = mismatches;
  assign pending_powers = power_queue.size();

  always @(posedge clk) begin
    logic [MOD_WIDTH-1:0] want;
    if (!rst_n) begin
      modulus_q   <= MOD_WIDTH'(mexp_pkg::MOD_RESET_VAL);
      mismatches  = 0;
      powers_seen = 0;
      power_queue.delete();
    end else begin
      if (in_valid && !in_stall)
        power_queue = {power_queue, predict_power(in_base, in_exponent, modulus_q)};
      if (out_valid && !out_stall) begin
        powers_seen++;
        if (power_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("ERROR: unexpected power %0d", out_power);
        end else begin
          want = power_queue.pop_front();
          if (want !== out_power) begin
            mismatches++;
            if (mismatches <= 10)
              $display("ERROR: power expected %0d got %0d", want, out_power);
          end
        end
      end
      // single register, index REG_MODULUS
      if (cfg_valid && cfg_ready && REG_MODULUS == 0) modulus_q <= cfg_modulus;
    end
  end

endmodule

### verif/tb_modular_exponentiation_unit.sv
// Testbench top for modular_exponentiation_unit: directed and random base/exponent
// transfers over several moduli, with random idling. Depends on mexp_pkg and mexp_checker.
`timescale 1ns / 100ps
module tb_modular_exponentiation_unit;

  localparam int MW = 32;
  localparam int EW = 63;
  localparam int BW = mexp_pkg::BASE_W;
  localparam int DRAIN_CYCLES = 63 + EW * 2 * (MW + 1) + 10;

  logic          clk;
  logic          rst_n;
  logic          in_valid;
  logic          in_stall;
  logic [BW-1:0] in_base;
  logic [EW-1:0] in_exponent;
  logic          out_valid;
  logic          out_stall;
  logic [MW-1:0] out_power;
  logic          cfg_valid;
  logic          cfg_ready;
  logic [MW-1:0] cfg_modulus;
  int            fail_count;
  int            pending_powers;
  int            powers_seen;
  int            send_idle_pct;
  int            recv_stall_pct;
  int            items_sent;

  modular_exponentiation_unit #(.MOD_WIDTH(MW), .EXP_WIDTH(EW)) u_dut (.*);

  mexp_checker #(.MOD_WIDTH(MW), .EXP_WIDTH(EW)) u_checker (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #400ms;
    $display("Test completed with failures");
    $finish;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // valid stays high after a transfer; the next item or drain() decides its level
  task automatic send_item(logic [BW-1:0] b, logic [EW-1:0] e);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_base     <= b;
    in_exponent <= e;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_powers != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_modulus(logic [MW-1:0] m);
    drain();
    cfg_valid   <= 1'b1;
    cfg_modulus <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // mostly short exponents keep the run fast; some full width
  task automatic random_item();
    logic [63:0] e;
    e = rand64();
    case ($urandom_range(3))
      0: e = e & 64'hFF;
      1: e = e & 64'hFFFF;
      2: e = e & 64'hFFFF_FFFF;
      default: ;
    endcase
    send_item(BW'(rand64()), EW'(e));
  endtask

  task automatic send_modulus_phase(logic [MW-1:0] m);
    set_modulus(m);
    send_item(0, 0);
    send_item('1, '1);
    send_item(7, 13);
    send_item(BW'(rand64()), EW'(rand64()));
  endtask

  initial begin
    rst_n = 0; in_valid = 0; in_base = 0; in_exponent = 0;
    cfg_valid = 0; cfg_modulus = 0;
    send_idle_pct = 0; recv_stall_pct = 0; items_sent = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed at reset modulus: zero exponent, zero base, extremes
    send_item(0, 0);
    send_item('1, 0);
    send_item(0, 5);
    send_item('1, '1);
    send_item(2, 62);
    send_item(BW'(64'd1000000007), 3);
    send_item(BW'(64'd1000000006), EW'(64'd1000000005));
    send_item(3, 1);
    send_modulus_phase(MW'(1));
    send_modulus_phase('1);
    send_modulus_phase(MW'(0));
    send_modulus_phase(MW'(2));
    send_modulus_phase(MW'(32'h8000_0000));

    set_modulus(MW'($urandom_range(3, 32'hFFFF_FFFF)));
    send_idle_pct = 20; recv_stall_pct = 46;
    repeat (37) random_item();
    set_modulus(MW'($urandom() | 1));
    send_idle_pct = 46; recv_stall_pct = 20;
    repeat (37) random_item();
    set_modulus('1);
    send_idle_pct = 0; recv_stall_pct = 0;
    repeat (37) random_item();

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d transfers, %0d powers checked, moduli from 0 to all ones.",
             items_sent, powers_seen);
    if (fail_count == 0 && pending_powers == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/mexp_pkg.sv
hw/rtl/mexp_cell.sv
hw/rtl/mexp_chain.sv
hw/rtl/modular_exponentiation_unit.sv
verif/mexp_checker.sv
verif/tb_modular_exponentiation_unit.sv
